FILE: src/svps_pkg.sv
`default_nettype none
package svps_pkg;
    localparam int unsigned VOICES_DEF    = 8;
    localparam int unsigned FRAC_BITS_DEF = 12;
    localparam logic [31:0] ENV_FULL      = 32'hFFFF_FFFF;
    localparam logic [31:0] RELEASE_RESET = 32'd298262;

    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_BAD      = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        KIND_ASSIGN  = 3'd0,
        KIND_IGNORE  = 3'd1,
        KIND_RELEASE = 3'd2,
        KIND_FRAME   = 3'd3,
        KIND_IDLE    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        MODE_FREE = 2'd0,
        MODE_HELD = 2'd1,
        MODE_REL  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PICK,
        ST_SCAN,
        ST_DIV,
        ST_EMIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [19:0] phase_step;
        logic [19:0] loop_start_frame;
        logic [19:0] loop_end_frame;
        logic [19:0] length_frames;
        logic [31:0] decay_step;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [3:0]  count;
        logic [19:0] sample_index;
        logic [11:0] fraction;
        logic [15:0] gain;
        logic        at_seam;
        logic        looped;
        logic        wrapped;
        logic        freed;
        logic        last;
    } t_out_item;
endpackage
`default_nettype wire

FILE: src/svps_if.sv
`default_nettype none
interface svps_in_if;
    import svps_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svps_out_if;
    import svps_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/svps_front.sv
`default_nettype none
// Two-entry command queue between the port and the voice engine.
module svps_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    svps_in_if.sink              i_in,
    output svps_pkg::t_in_item   o_item,
    output logic                 o_valid,
    input  wire logic            i_take
);
    import svps_pkg::*;
    t_in_item   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    // nothing is accepted while reset is held
    assign i_in.ready = i_rst_n && (r_cnt != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_take && o_valid;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_in.data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_cnt != 2'd0)) else $error("pop from empty queue");
endmodule
`default_nettype wire

FILE: src/svps_divu.sv
`default_nettype none
// Restoring remainder unit, one bit per cycle (33-bit dividend, 32-bit divisor).
module svps_divu (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [32:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_rem
);
    logic [32:0] r_num;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] trial;

    assign trial  = {r_rem, r_num[32]} - {2'b0, r_den};
    assign o_rem  = r_rem[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_num <= {r_num[31:0], 1'b0};
                if (!trial[33]) r_rem <= trial[32:0];
                else            r_rem <= {r_rem[31:0], r_num[32]};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: src/svps_back.sv
`default_nettype none
// Voice engine: one voice per scan step, divider for loop wrap.
module svps_back #(
    parameter int unsigned VOICES    = svps_pkg::VOICES_DEF,
    parameter int unsigned FRAC_BITS = svps_pkg::FRAC_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [31:0]     i_release_step,
    input  svps_pkg::t_in_item   i_item,
    input  wire logic            i_valid,
    output logic                 o_take,
    svps_out_if.source           o_out
);
    import svps_pkg::*;
    localparam int VW = $clog2(VOICES);
    localparam int CW = $clog2(VOICES + 1);

    t_mode       r_mode  [VOICES];
    logic [3:0]  r_ch    [VOICES];
    logic [6:0]  r_note  [VOICES];
    logic [31:0] r_phase [VOICES];
    logic [19:0] r_step  [VOICES];
    logic [31:0] r_ls    [VOICES];
    logic [31:0] r_le    [VOICES];
    logic [31:0] r_len   [VOICES];
    logic [31:0] r_env   [VOICES];
    logic [31:0] r_dec   [VOICES];
    logic [31:0] r_rel   [VOICES];
    logic [31:0] r_age   [VOICES];
    logic [31:0] r_age_ctr;

    t_state      r_st, n_st;
    t_in_item    r_cur;
    logic [VW:0] r_i;
    logic [VW-1:0] r_best;
    logic [1:0]  r_pri;
    logic [CW-1:0] r_cnt;
    logic        r_any;
    t_out_item   r_res;
    logic        r_ovalid;
    logic        r_dstart;

    logic [VW-1:0] vi;
    logic [32:0]   np;
    logic          looped;
    logic [31:0]   rate;
    logic [31:0]   rel_eff;
    logic          d_done;
    logic [31:0]   d_rem;
    logic          last_voice;
    logic          more_active;
    logic          is_assign;
    t_out_item     done_res;

    assign vi         = r_i[VW-1:0];
    assign np         = {1'b0, r_phase[vi]} + {13'b0, r_step[vi]};
    assign looped     = r_le[vi] > r_ls[vi];
    assign rel_eff    = (i_release_step == 32'd0) ? 32'd1 : i_release_step;
    assign rate       = (r_mode[vi] == MODE_REL) ? r_rel[vi] : r_dec[vi];
    assign last_voice = (r_i == (VW+1)'(VOICES - 1));
    assign is_assign  = (r_cur.command == CMD_NOTE_ON) && (r_cur.velocity != 7'd0);

    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;
    assign o_take      = (r_st == ST_IDLE) && i_valid && !r_ovalid;

    // any active voice above the one being scanned: if none, this frame is the last
    always_comb begin
        more_active = 1'b0;
        for (int k = 0; k < VOICES; k++) begin
            if (k > int'(vi) && r_mode[k] != MODE_FREE) more_active = 1'b1;
        end
    end

    // single closing result of a transaction
    always_comb begin
        done_res      = '0;
        done_res.last = 1'b1;
        if (is_assign) begin
            done_res.kind  = KIND_ASSIGN;
            done_res.slot  = 3'(r_best);
            done_res.count = 4'(r_cnt);
        end else if (r_cur.command == CMD_NOTE_ON) begin
            done_res.kind  = KIND_IGNORE;
        end else if (r_cur.command == CMD_NOTE_OFF) begin
            done_res.kind  = KIND_RELEASE;
            done_res.count = 4'(r_cnt);
        end else begin
            done_res.kind  = KIND_IDLE;
        end
    end

    svps_divu u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (np - {1'b0, r_ls[vi]}),
        .i_den   (r_le[vi] - r_ls[vi]),
        .o_done  (d_done),
        .o_rem   (d_rem)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (o_take) begin
                n_st = (i_item.command == CMD_NOTE_ON && i_item.velocity != 7'd0) ?
                       ST_PICK : ST_SCAN;
                if (i_item.command == CMD_BAD ||
                    (i_item.command == CMD_NOTE_ON && i_item.velocity == 7'd0))
                    n_st = ST_DONE;
            end
            ST_PICK: if (last_voice) n_st = ST_DONE;
            ST_SCAN: if (!r_ovalid || o_out.ready) begin
                if (r_cur.command == CMD_TICK && r_mode[vi] != MODE_FREE &&
                    looped && np >= {1'b0, r_le[vi]})
                    n_st = ST_DIV;
                else if (last_voice) n_st = ST_DONE;
            end
            ST_DIV:  if (d_done) n_st = last_voice ? ST_DONE : ST_SCAN;
            ST_DONE: if (!r_ovalid || o_out.ready) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_dstart <= 1'b0;
        if (o_out.valid && o_out.ready) r_ovalid <= 1'b0;
        case (r_st)
            ST_IDLE: if (o_take) begin
                r_cur  <= i_item;
                r_i    <= '0;
                r_best <= '0;
                r_pri  <= 2'd3;
                r_cnt  <= '0;
                r_any  <= 1'b0;
            end
            ST_PICK: begin
                if (r_mode[vi] != MODE_FREE) r_cnt <= r_cnt + CW'(1);
                if (r_mode[vi] == MODE_FREE && r_pri != 2'd0) begin
                    r_best <= vi; r_pri <= 2'd0;
                end else if (r_mode[vi] == MODE_REL && r_pri > 2'd1) begin
                    r_best <= vi; r_pri <= 2'd1;
                end else if (r_mode[vi] == MODE_HELD && (r_pri == 2'd3 ||
                             (r_pri == 2'd2 && r_age[vi] < r_age[r_best]))) begin
                    r_best <= vi; r_pri <= 2'd2;
                end
                r_i <= r_i + 1'b1;
            end
            ST_SCAN: if (!r_ovalid || o_out.ready) begin
                if (r_cur.command == CMD_NOTE_OFF) begin
                    if (r_mode[vi] == MODE_HELD && r_note[vi] == r_cur.note &&
                        r_ch[vi] == r_cur.channel) begin
                        r_mode[vi] <= MODE_REL;
                        r_rel[vi]  <= rel_eff;
                        r_cnt      <= r_cnt + CW'(1);
                    end
                    r_i <= r_i + 1'b1;
                end else if (r_mode[vi] != MODE_FREE) begin
                    if (looped && np >= {1'b0, r_le[vi]}) begin
                        r_dstart <= 1'b1;
                    end else begin
                        r_any    <= 1'b1;
                        r_ovalid <= 1'b1;
                        r_res.kind         <= KIND_FRAME;
                        r_res.slot         <= 3'(vi);
                        r_res.count        <= '0;
                        r_res.sample_index <= 20'(r_phase[vi] >> FRAC_BITS);
                        r_res.fraction     <= 12'(r_phase[vi][FRAC_BITS-1:0]);
                        r_res.gain         <= r_env[vi][31:16];
                        r_res.at_seam      <= ({1'b0, r_phase[vi] >> FRAC_BITS} + 33'd1) >=
                            {1'b0, (looped ? r_le[vi] : r_len[vi]) >> FRAC_BITS};
                        r_res.looped       <= looped;
                        r_res.wrapped      <= 1'b0;
                        r_res.last         <= !more_active;
                        r_phase[vi] <= np[31:0];
                        if (!looped && np >= {1'b0, r_len[vi]}) begin
                            r_mode[vi]   <= MODE_FREE;
                            r_res.freed  <= 1'b1;
                        end else if (rate >= r_env[vi]) begin
                            r_env[vi]    <= '0;
                            r_mode[vi]   <= MODE_FREE;
                            r_res.freed  <= 1'b1;
                        end else begin
                            r_env[vi]    <= r_env[vi] - rate;
                            r_res.freed  <= 1'b0;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            ST_DIV: if (d_done) begin
                r_any    <= 1'b1;
                r_ovalid <= 1'b1;
                r_res.kind         <= KIND_FRAME;
                r_res.slot         <= 3'(vi);
                r_res.count        <= '0;
                r_res.sample_index <= 20'(r_phase[vi] >> FRAC_BITS);
                r_res.fraction     <= 12'(r_phase[vi][FRAC_BITS-1:0]);
                r_res.gain         <= r_env[vi][31:16];
                r_res.at_seam      <= ({1'b0, r_phase[vi] >> FRAC_BITS} + 33'd1) >=
                                      {1'b0, r_le[vi] >> FRAC_BITS};
                r_res.looped       <= 1'b1;
                r_res.wrapped      <= 1'b1;
                r_res.last         <= !more_active;
                r_phase[vi] <= r_ls[vi] + d_rem;
                if (rate >= r_env[vi]) begin
                    r_env[vi]   <= '0;
                    r_mode[vi]  <= MODE_FREE;
                    r_res.freed <= 1'b1;
                end else begin
                    r_env[vi]   <= r_env[vi] - rate;
                    r_res.freed <= 1'b0;
                end
                r_i <= r_i + 1'b1;
            end
            ST_DONE: if (!r_ovalid || o_out.ready) begin
                // a tick with active voices already flagged its final frame
                if (!(r_cur.command == CMD_TICK && r_any)) begin
                    r_ovalid <= 1'b1;
                    r_res    <= done_res;
                end
                if (is_assign) begin
                    r_mode[r_best]  <= MODE_HELD;
                    r_ch[r_best]    <= r_cur.channel;
                    r_note[r_best]  <= r_cur.note;
                    r_phase[r_best] <= '0;
                    r_step[r_best]  <= r_cur.phase_step;
                    r_ls[r_best]    <= 32'({12'b0, r_cur.loop_start_frame} << FRAC_BITS);
                    r_le[r_best]    <= 32'({12'b0, r_cur.loop_end_frame} << FRAC_BITS);
                    r_len[r_best]   <= 32'({12'b0, r_cur.length_frames} << FRAC_BITS);
                    r_env[r_best]   <= ENV_FULL;
                    r_dec[r_best]   <= (r_cur.decay_step == 32'd0) ? 32'd1 : r_cur.decay_step;
                    r_rel[r_best]   <= '0;
                    r_age[r_best]   <= r_age_ctr + 32'd1;
                    r_age_ctr       <= r_age_ctr + 32'd1;
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_age_ctr <= '0;
            r_dstart  <= 1'b0;
            r_cnt     <= '0;
            r_i       <= '0;
            for (int k = 0; k < VOICES; k++) begin
                r_mode[k] <= MODE_FREE;
                r_age[k]  <= '0;
            end
        end else begin
            r_st <= n_st;
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (r_st == ST_IDLE)) else $error("take outside idle");
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dstart |=> (r_st == ST_DIV)) else $error("divider start without wait");
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(VOICES)) else $error("count above pool size");
endmodule
`default_nettype wire

FILE: src/sampler_voice_pool_sequencer_core.sv
`default_nettype none
// Sampler voice pool: note on/off and frame ticks over an eight-voice pool.
// Note on: the pick step visits each voice in turn (one voice per cycle), then the
// result is emitted. Note off and tick scan every voice; a tick also waits on
// the bit-serial remainder unit at each loop wrap. Frames are held while the sink
// is not ready; the next transaction is not taken until the last result has left.
// Reset (sync, active low) frees all voices, clears ages, loads release step.
module sampler_voice_pool_sequencer_core #(
    parameter int unsigned VOICES    = svps_pkg::VOICES_DEF,
    parameter int unsigned FRAC_BITS = svps_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    svps_in_if.sink          i_in,
    svps_out_if.source       o_out
);
    import svps_pkg::*;

    logic [31:0] r_release_step;
    t_in_item    q_item;
    logic        q_valid;
    logic        q_take;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_release_step <= RELEASE_RESET;
        else if (i_cfg_we) r_release_step <= i_cfg_wdata;
    end

    // front: command queue
    svps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_item  (q_item),
        .o_valid (q_valid),
        .i_take  (q_take)
    );

    // back: voice engine
    svps_back #(.VOICES(VOICES), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_release_step (r_release_step),
        .i_item         (q_item),
        .i_valid        (q_valid),
        .o_take         (q_take),
        .o_out          (o_out)
    );
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import svps_pkg::*;

    localparam int NV   = 8;
    localparam int FRAC = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    svps_in_if  in_ch ();
    svps_out_if out_ch ();

    sampler_voice_pool_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the voice pool, updated once per accepted input transaction.
    t_mode       v_mode  [NV];
    logic [3:0]  v_chan  [NV];
    logic [6:0]  v_note  [NV];
    logic [31:0] v_phase [NV];
    logic [19:0] v_step  [NV];
    logic [31:0] v_ls    [NV];
    logic [31:0] v_le    [NV];
    logic [31:0] v_len   [NV];
    logic [31:0] v_env   [NV];
    logic [31:0] v_decay [NV];
    logic [31:0] v_rel   [NV];
    logic [31:0] v_age   [NV];
    logic [31:0] age_ctr;
    logic [31:0] rel_step;

    t_out_item pending_results[$];
    int        errors = 0;
    bit        stim_done = 0;
    bit        long_hold = 0;

    function automatic t_out_item blank(t_kind k);
        t_out_item r;
        r = '0;
        r.kind = k;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void pool_reset();
        for (int i = 0; i < NV; i++) begin
            v_mode[i] = MODE_FREE; v_chan[i] = '0; v_note[i] = '0; v_phase[i] = '0;
            v_step[i] = '0; v_ls[i] = '0; v_le[i] = '0; v_len[i] = '0;
            v_env[i] = '0; v_decay[i] = '0; v_rel[i] = '0; v_age[i] = '0;
        end
        age_ctr  = '0;
        rel_step = RELEASE_RESET;
    endfunction

    // Advances the shadow pool and queues the results this transaction causes.
    function automatic void predict_voices(t_in_item it);
        int        active, s, n;
        t_out_item r;
        logic [32:0] np;
        logic [31:0] rate;
        logic [20:0] idx, bound;
        bit        lp;
        n = 0;
        case (t_cmd'(it.command))
            CMD_NOTE_ON: begin
                if (it.velocity == 0) begin
                    pending_results.push_back(blank(KIND_IGNORE));
                end else begin
                    active = 0;
                    s = -1;
                    for (int i = 0; i < NV; i++) if (v_mode[i] != MODE_FREE) active++;
                    for (int i = 0; i < NV && s < 0; i++) if (v_mode[i] == MODE_FREE) s = i;
                    for (int i = 0; i < NV && s < 0; i++) if (v_mode[i] == MODE_REL) s = i;
                    if (s < 0) begin
                        s = 0;
                        for (int i = 1; i < NV; i++) if (v_age[i] < v_age[s]) s = i;
                    end
                    v_mode[s]  = MODE_HELD;
                    v_chan[s]  = it.channel;
                    v_note[s]  = it.note;
                    v_phase[s] = '0;
                    v_step[s]  = it.phase_step;
                    v_ls[s]    = {it.loop_start_frame, 12'b0};
                    v_le[s]    = {it.loop_end_frame, 12'b0};
                    v_len[s]   = {it.length_frames, 12'b0};
                    v_env[s]   = ENV_FULL;
                    v_decay[s] = (it.decay_step == 0) ? 32'd1 : it.decay_step;
                    v_rel[s]   = '0;
                    age_ctr++;
                    v_age[s]   = age_ctr;
                    r = blank(KIND_ASSIGN);
                    r.slot  = s[2:0];
                    r.count = active[3:0];
                    pending_results.push_back(r);
                end
            end
            CMD_NOTE_OFF: begin
                for (int i = 0; i < NV; i++)
                    if (v_mode[i] == MODE_HELD && v_note[i] == it.note
                            && v_chan[i] == it.channel) begin
                        v_mode[i] = MODE_REL;
                        v_rel[i]  = (rel_step == 0) ? 32'd1 : rel_step;
                        n++;
                    end
                r = blank(KIND_RELEASE);
                r.count = n[3:0];
                pending_results.push_back(r);
            end
            CMD_TICK: begin
                for (int i = 0; i < NV; i++) begin
                    if (v_mode[i] == MODE_FREE) continue;
                    r = '0;
                    r.kind = KIND_FRAME;
                    r.slot = i[2:0];
                    lp = v_le[i] > v_ls[i];
                    idx = {1'b0, v_phase[i][31:FRAC]};
                    bound = {1'b0, lp ? v_le[i][31:FRAC] : v_len[i][31:FRAC]};
                    r.sample_index = idx[19:0];
                    r.fraction = v_phase[i][FRAC-1:0];
                    r.gain = v_env[i][31:16];
                    r.at_seam = (idx + 1) >= bound;
                    r.looped = lp;
                    np = {1'b0, v_phase[i]} + v_step[i];
                    if (lp && np >= {1'b0, v_le[i]}) begin
                        np = v_ls[i] + (np - v_ls[i]) % ({1'b0, v_le[i]} - v_ls[i]);
                        r.wrapped = 1'b1;
                    end else if (!lp && np >= {1'b0, v_len[i]}) begin
                        v_mode[i] = MODE_FREE;
                        r.freed = 1'b1;
                    end
                    v_phase[i] = np[31:0];
                    if (v_mode[i] != MODE_FREE) begin
                        rate = (v_mode[i] == MODE_REL) ? v_rel[i] : v_decay[i];
                        if (rate >= v_env[i]) begin
                            v_env[i] = '0;
                            v_mode[i] = MODE_FREE;
                            r.freed = 1'b1;
                        end else begin
                            v_env[i] = v_env[i] - rate;
                        end
                    end
                    pending_results.push_back(r);
                    n++;
                end
                if (n == 0) pending_results.push_back(blank(KIND_IDLE));
                else pending_results[$].last = 1'b1;
            end
            default: pending_results.push_back(blank(KIND_IDLE));
        endcase
    endfunction

    // Result side: random back-pressure, and a checker at each rising edge.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            int w;
            @(negedge i_clk);
            if (long_hold) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                long_hold = 0;
            end
            w = (($urandom_range(0, 3) == 0) && !stim_done) ? $urandom_range(0, 18) : 0;
            if (w > 0) begin
                out_ch.ready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r, got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got !== exp_r) begin
                    $display("%0t: expected %p", $time, exp_r);
                    $display("%0t: actual   %p", $time, got);
                    errors++;
                end
            end
        end
    end

    // One input transaction; the shadow updates at the accepting edge.
    // Valid stays high into the next call unless an idle gap is drawn.
    task automatic send(t_in_item it, bit gaps);
        int w;
        w = (gaps && $urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
        if (w > 0) begin
            in_ch.valid <= 1'b0;
            repeat (w) @(negedge i_clk);
        end
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_voices(it);
        @(negedge i_clk);
    endtask

    task automatic drain_then_cfg(logic [31:0] v);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        rel_step = v;
    endtask

    function automatic t_in_item mk(t_cmd c, int ch, int nt, int vel,
            int st, int ls, int le, int len, logic [31:0] dec);
        t_in_item it;
        it.command = c; it.channel = 4'(ch); it.note = 7'(nt); it.velocity = 7'(vel);
        it.phase_step = 20'(st); it.loop_start_frame = 20'(ls);
        it.loop_end_frame = 20'(le); it.length_frames = 20'(len); it.decay_step = dec;
        return it;
    endfunction

    // Rows whose result is plain from the model: reset state, ignore, release of no voice, error code, first assign.
    function automatic bit typed_exp(int row, output t_out_item e);
        e = '0;
        case (row)
            0, 3:    e = blank(KIND_IDLE);
            1:       e = blank(KIND_IGNORE);
            2:       e = blank(KIND_RELEASE);
            4:       e = blank(KIND_ASSIGN);   // first voice, none active
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Mostly playable notes: short samples, steps near a frame, quick decay.
    function automatic t_in_item rand_item();
        t_in_item it;
        int p;
        it = '0;
        p = $urandom_range(0, 99);
        it.channel  = 4'($urandom_range(0, 3));
        it.note     = 7'($urandom_range(60, 63));
        it.velocity = 7'($urandom_range(1, 127));
        if (p < 35) begin
            it.command = CMD_NOTE_ON;
            it.phase_step = 20'($urandom_range(0, 20000));
            it.loop_start_frame = 20'($urandom_range(0, 20));
            it.loop_end_frame = 20'($urandom_range(0, 40));
            it.length_frames = 20'($urandom_range(0, 60));
            it.decay_step = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 1 << 29);
        end else if (p < 55) begin
            it.command = CMD_NOTE_OFF;
        end else if (p < 92) begin
            it.command = CMD_TICK;
        end else begin
            it = t_in_item'($bits(t_in_item)'({$urandom(), $urandom(), $urandom(),
                                                $urandom(), $urandom()}));
            if (p < 94) it.velocity = 0;
        end
        return it;
    endfunction

    // Directed rows; the first ones carry a typed-in result, the rest use the shadow pool.
    t_in_item directed[$];

    initial begin
        t_out_item row_exp;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        pool_reset();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed = '{
            mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(CMD_NOTE_ON, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(CMD_NOTE_OFF, 15, 127, 0, 0, 0, 0, 0, 0),
            mk(CMD_BAD, 15, 127, 127, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, '1),
            mk(CMD_NOTE_ON, 15, 127, 127, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF, 0),
            mk(CMD_NOTE_ON, 1, 60, 64, 4096, 4, 10, 12, 32'h1000_0000),
            mk(CMD_NOTE_ON, 2, 61, 1, 5000, 0, 0, 3, '1),
            mk(CMD_NOTE_ON, 3, 62, 100, 'hFFFFF, 2, 7, 9, 5),
            mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(CMD_NOTE_ON, 4, 63, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_ON, 5, 64, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_ON, 6, 65, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_ON, 7, 66, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_ON, 8, 67, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_ON, 9, 68, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_ON, 10, 69, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_ON, 1, 60, 9, 100, 0, 0, 100, 2),
            mk(CMD_NOTE_OFF, 1, 60, 0, 0, 0, 0, 0, 0),
            mk(CMD_NOTE_ON, 11, 70, 9, 100, 0, 0, 100, 2),
            mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0),
            mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0)
        };
        foreach (directed[i]) begin
            send(directed[i], 0);
            if (typed_exp(i, row_exp)) pending_results[$] = row_exp;
        end

        // Release step phases: zero (acts as one), all ones (frees at once), a random value, the reset value.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: drain_then_cfg(32'd0);
                1: drain_then_cfg(32'hFFFF_FFFF);
                2: drain_then_cfg($urandom_range(1, 1 << 28));
                default: drain_then_cfg(RELEASE_RESET);
            endcase
            if (ph == 1) long_hold = 1;
            for (int k = 0; k < 90; k++) send(rand_item(), ph != 1);
        end
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        stim_done = 1;
        if (errors == 0) begin
            $display("sampler_voice_pool_sequencer_core: match");
        end else begin
            $display("sampler_voice_pool_sequencer_core: mismatch");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("sampler_voice_pool_sequencer_core: mismatch");
        $finish;
    end
endmodule
